// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lfu_pkg.sv =====
package lfu_pkg;

  localparam int KEY_W  = 10;
  localparam int CAP_W  = 5;
  localparam int HITS_W = 32;

  // split of the key for the history index reduction tables
  localparam int KEY_LO_W = 8;
  localparam int KEY_HI_W = KEY_W - KEY_LO_W;

  localparam int SLOTS_DEF      = 16;
  localparam int KEY_SPACE_DEF  = 1024;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_SEARCH
  } lfu_state_e;

  // per-cell control from the sequencer
  typedef struct packed {
    logic occupied;
    logic load;
    logic bump;
  } lfu_cell_ctl_t;

endpackage

// ===== rtl/core/lfu_req_if.sv =====
interface lfu_req_if;
  import lfu_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] page_key;

  modport source (output valid, output page_key, input ready);
  modport sink   (input valid, input page_key, output ready);
endinterface

// ===== rtl/core/lfu_res_if.sv =====
interface lfu_res_if #(
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
);
  import lfu_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic                  placed;
  logic                  replaced_valid;
  logic [KEY_W-1:0]      replaced_key;
  logic [COUNT_BITS-1:0] request_count;
  logic [HITS_W-1:0]     hit_total;

  modport source (output valid, output hit, output placed, output replaced_valid,
                  output replaced_key, output request_count, output hit_total,
                  input ready);
  modport sink   (input valid, input hit, input placed, input replaced_valid,
                  input replaced_key, input request_count, input hit_total,
                  output ready);
endinterface

// ===== rtl/core/lfu_hist_mem.sv =====
module lfu_hist_mem #(
  parameter int KEY_SPACE  = lfu_pkg::KEY_SPACE_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
  parameter int HIDX_W     = $clog2(KEY_SPACE)
) (
  input  logic                  clk_i,
  input  logic                  re_i,
  input  logic [HIDX_W-1:0]     raddr_i,
  output logic [COUNT_BITS-1:0] rdata_o,
  input  logic                  we_i,
  input  logic [HIDX_W-1:0]     waddr_i,
  input  logic [COUNT_BITS-1:0] wdata_i
);

  logic [COUNT_BITS-1:0] mem_q [KEY_SPACE];
  logic [COUNT_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lfu_cell.sv =====
module lfu_cell #(
  parameter int SLOTS      = lfu_pkg::SLOTS_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
  parameter int IDX        = 0,
  parameter int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lfu_pkg::lfu_cell_ctl_t        ctl_i,
  input  logic [lfu_pkg::KEY_W-1:0]     key_i,
  input  logic [COUNT_BITS-1:0]         cnt_i,
  output logic                          match_o,
  // minimum-search token from the left neighbour
  input  logic                          tok_vld_i,
  input  logic [COUNT_BITS-1:0]         tok_cnt_i,
  input  logic [SLOT_W-1:0]             tok_idx_i,
  input  logic [lfu_pkg::KEY_W-1:0]     tok_key_i,
  // token handed to the right neighbour
  output logic                          tok_vld_o,
  output logic [COUNT_BITS-1:0]         tok_cnt_o,
  output logic [SLOT_W-1:0]             tok_idx_o,
  output logic [lfu_pkg::KEY_W-1:0]     tok_key_o
);
  import lfu_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [KEY_W-1:0]      key_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  tok_vld_q;
  logic [COUNT_BITS-1:0] tok_cnt_q;
  logic [SLOT_W-1:0]     tok_idx_q;
  logic [KEY_W-1:0]      tok_key_q;
  logic                  take_own;

  assign match_o = ctl_i.occupied && (key_q == key_i);

  // ties go to the later slot
  assign take_own = ctl_i.occupied && (!tok_vld_i || (cnt_q <= tok_cnt_i));

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      key_q <= key_i;
      cnt_q <= cnt_i;
    end else if (ctl_i.bump && (cnt_q != COUNT_MAX)) begin
      cnt_q <= cnt_q + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i || ctl_i.occupied;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_own) begin
      tok_cnt_q <= cnt_q;
      tok_idx_q <= SLOT_W'(IDX);
      tok_key_q <= key_q;
    end else begin
      tok_cnt_q <= tok_cnt_i;
      tok_idx_q <= tok_idx_i;
      tok_key_q <= tok_key_i;
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_cnt_o = tok_cnt_q;
  assign tok_idx_o = tok_idx_q;
  assign tok_key_o = tok_key_q;

endmodule

// ===== rtl/core/lfu_cache_replacement.sv =====
// LFU page cache with request history. One page key per input beat, one result beat per
// request. A history table of KEY_SPACE counters (key taken modulo KEY_SPACE) counts every
// request, cached or not; SLOTS cells hold the cached keys with their own counts. A hit
// bumps the cell's count; a miss fills the next free cell while occupancy is below the
// capacity register (clamped to SLOTS, zero disables placement); otherwise the cell with
// the smallest count (later cell on ties) is replaced when the request's history count is
// strictly greater. All counters saturate.
// Each item is a history read, then read-modify-write and cell update; the finish waits
// for a free result register. A miss with the cache full first lets the minimum-count
// token ripple once through the chain of cells. After reset the history table is swept
// to zero, one entry per cycle, through all KEY_SPACE entries; no beat is accepted until then.
// The capacity register may be written at any time but only while idle has defined effect.
`include "assert_macros.svh"

module lfu_cache_replacement #(
  parameter int SLOTS      = lfu_pkg::SLOTS_DEF,
  parameter int KEY_SPACE  = lfu_pkg::KEY_SPACE_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata_i,
  lfu_req_if.sink                   req_i,
  lfu_res_if.source                 res_o
);
  import lfu_pkg::*;

  localparam int HIDX_W = $clog2(KEY_SPACE);
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OCC_W  = $clog2(SLOTS + 1);
  localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int LO_N   = 2 ** KEY_LO_W;
  localparam int HI_N   = 2 ** KEY_HI_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [HITS_W-1:0]     HITS_MAX  = {HITS_W{1'b1}};

  // Key modulo KEY_SPACE: remainders of the low and high key parts are tabulated at
  // elaboration, their sum is below twice KEY_SPACE, so one subtract corrects it.
  typedef logic [HIDX_W-1:0] lo_tab_t [LO_N];
  typedef logic [HIDX_W-1:0] hi_tab_t [HI_N];

  function automatic lo_tab_t build_lo();
    lo_tab_t t;
    for (int i = 0; i < LO_N; i++) begin
      t[i] = HIDX_W'(i % KEY_SPACE);
    end
    return t;
  endfunction

  function automatic hi_tab_t build_hi();
    hi_tab_t t;
    for (int i = 0; i < HI_N; i++) begin
      t[i] = HIDX_W'((i * LO_N) % KEY_SPACE);
    end
    return t;
  endfunction

  localparam lo_tab_t LO_MOD = build_lo();
  localparam hi_tab_t HI_MOD = build_hi();

  // control state
  lfu_state_e        state_q, state_d;
  logic [HIDX_W-1:0] clr_cnt_q;
  logic [SLOT_W-1:0] srch_cnt_q;
  logic [OCC_W-1:0]  occupancy_q;
  logic [HITS_W-1:0] hits_q, hits_d;
  logic [CAP_W-1:0]  capacity_q;
  logic              out_valid_q;

  // payload held across the item
  logic [KEY_W-1:0]      key_q;
  logic [HIDX_W-1:0]     hidx_q;
  logic [COUNT_BITS-1:0] reqc_q;

  // result register
  logic                  res_hit_q;
  logic                  res_placed_q;
  logic                  res_rvalid_q;
  logic [KEY_W-1:0]      res_rkey_q;
  logic [COUNT_BITS-1:0] res_count_q;
  logic [HITS_W-1:0]     res_total_q;

  // history index of the incoming key
  logic [HIDX_W:0]   hsum;
  logic [HIDX_W-1:0] hidx_in;

  // history memory port
  logic                  mem_re;
  logic                  mem_we;
  logic [HIDX_W-1:0]     mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] hist_rd;
  logic [COUNT_BITS-1:0] reqc_now;

  // decisions
  logic             in_acc;
  logic             out_free;
  logic             found;
  logic             cap_zero;
  logic             room;
  logic             clr_last;
  logic             srch_done;
  logic             eval_go;
  logic             fill_go;
  logic             launch;
  logic             search_end;
  logic             repl_go;
  logic             emit;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_eff;

  // cell chain
  lfu_cell_ctl_t         cell_ctl [SLOTS];
  logic [SLOTS-1:0]      match;
  logic                  tok_vld [SLOTS+1];
  logic [COUNT_BITS-1:0] tok_cnt [SLOTS+1];
  logic [SLOT_W-1:0]     tok_idx [SLOTS+1];
  logic [KEY_W-1:0]      tok_key [SLOTS+1];

  assign hsum = {1'b0, LO_MOD[req_i.page_key[KEY_LO_W-1:0]]}
              + {1'b0, HI_MOD[req_i.page_key[KEY_W-1:KEY_LO_W]]};
  assign hidx_in = (hsum >= (HIDX_W+1)'(KEY_SPACE))
                 ? HIDX_W'(hsum - (HIDX_W+1)'(KEY_SPACE))
                 : hsum[HIDX_W-1:0];

  lfu_hist_mem #(
    .KEY_SPACE (KEY_SPACE),
    .COUNT_BITS(COUNT_BITS),
    .HIDX_W    (HIDX_W)
  ) u_hist (
    .clk_i  (clk_i),
    .re_i   (mem_re),
    .raddr_i(hidx_in),
    .rdata_o(hist_rd),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata)
  );

  assign reqc_now = (hist_rd == COUNT_MAX) ? hist_rd : hist_rd + COUNT_BITS'(1);

  // ---------------------------------------------------------------------------
  // Chain of slot cells. Key compare is parallel; the minimum-count token moves
  // one cell to the right per cycle, so the last cell holds the victim once the
  // token has passed every cell while the slot contents stayed stable.
  // ---------------------------------------------------------------------------
  assign tok_vld[0] = 1'b0;
  assign tok_cnt[0] = '0;
  assign tok_idx[0] = '0;
  assign tok_key[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    always_comb begin
      cell_ctl[i].occupied = OCC_W'(i) < occupancy_q;
      cell_ctl[i].load     = (fill_go && (occupancy_q == OCC_W'(i)))
                          || (repl_go && (tok_idx[SLOTS] == SLOT_W'(i)));
      cell_ctl[i].bump     = eval_go && found && match[i];
    end

    lfu_cell #(
      .SLOTS     (SLOTS),
      .COUNT_BITS(COUNT_BITS),
      .IDX       (i),
      .SLOT_W    (SLOT_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (cell_ctl[i]),
      .key_i    (key_q),
      .cnt_i    (eval_go ? reqc_now : reqc_q),
      .match_o  (match[i]),
      .tok_vld_i(tok_vld[i]),
      .tok_cnt_i(tok_cnt[i]),
      .tok_idx_i(tok_idx[i]),
      .tok_key_i(tok_key[i]),
      .tok_vld_o(tok_vld[i+1]),
      .tok_cnt_o(tok_cnt[i+1]),
      .tok_idx_o(tok_idx[i+1]),
      .tok_key_o(tok_key[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Decisions
  // ---------------------------------------------------------------------------
  assign in_acc    = req_i.valid && req_i.ready;
  assign out_free  = !out_valid_q || res_o.ready;
  assign found     = |match;
  assign cap_ext   = CMP_W'(capacity_q);
  assign cap_eff   = (cap_ext > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : cap_ext;
  assign cap_zero  = (cap_eff == '0);
  assign room      = CMP_W'(occupancy_q) < cap_eff;
  assign clr_last  = (clr_cnt_q == HIDX_W'(KEY_SPACE - 1));
  assign srch_done = (srch_cnt_q == SLOT_W'(SLOTS - 1));

  // hold the finishing cycle until the result register is free
  assign eval_go    = (state_q == ST_EVAL) && out_free;
  assign fill_go    = eval_go && !found && !cap_zero && room;
  assign launch     = eval_go && !found && !cap_zero && !room;
  assign search_end = (state_q == ST_SEARCH) && srch_done && out_free;
  assign repl_go    = search_end && (reqc_q > tok_cnt[SLOTS]);
  assign emit       = (eval_go && !launch) || search_end;

  assign hits_d = (eval_go && found && (hits_q != HITS_MAX)) ? hits_q + HITS_W'(1) : hits_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (launch) begin
          state_d = ST_SEARCH;
        end else if (eval_go) begin
          state_d = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (search_end) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    req_i.ready = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = hidx_q;
    mem_wdata   = reqc_now;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        req_i.ready = 1'b1;
        mem_re      = req_i.valid;
      end
      ST_EVAL: begin
        mem_we = eval_go;
      end
      ST_SEARCH: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      srch_cnt_q  <= '0;
      occupancy_q <= '0;
      hits_q      <= '0;
      capacity_q  <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + HIDX_W'(1);
      end
      if (launch) begin
        srch_cnt_q <= '0;
      end else if ((state_q == ST_SEARCH) && !srch_done) begin
        srch_cnt_q <= srch_cnt_q + SLOT_W'(1);
      end
      if (fill_go) begin
        occupancy_q <= occupancy_q + OCC_W'(1);
      end
      hits_q <= hits_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q  <= req_i.page_key;
      hidx_q <= hidx_in;
    end
    if (eval_go) begin
      reqc_q <= reqc_now;
    end
    if (emit) begin
      res_hit_q    <= eval_go && found;
      res_placed_q <= fill_go || repl_go;
      res_rvalid_q <= repl_go;
      res_rkey_q   <= repl_go ? tok_key[SLOTS] : '0;
      res_count_q  <= eval_go ? reqc_now : reqc_q;
      res_total_q  <= hits_d;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.hit            = res_hit_q;
  assign res_o.placed         = res_placed_q;
  assign res_o.replaced_valid = res_rvalid_q;
  assign res_o.replaced_key   = res_rkey_q;
  assign res_o.request_count  = res_count_q;
  assign res_o.hit_total      = res_total_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ASSERT_NEXT(a_accept_to_eval, in_acc, state_q == ST_EVAL, "beat not evaluated")
  `ASSERT_IMPL(a_occ_bound, 1'b1, occupancy_q <= OCC_W'(SLOTS), "occupancy too high")
  `ASSERT_IMPL(a_unique_key, state_q == ST_EVAL, $onehot0(match), "key in two slots")
  `ASSERT_IMPL(a_repl_placed, out_valid_q && res_o.replaced_valid, res_o.placed && !res_o.hit, "bad evict")
  `ASSERT_NEXT(a_fill_step, fill_go, occupancy_q == $past(occupancy_q) + OCC_W'(1), "fill lost")

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfu_pkg::*;

  localparam int NUM_SLOTS = SLOTS_DEF;
  localparam int HIST_SIZE = KEY_SPACE_DEF;
  localparam int CNT_W     = COUNT_BITS_DEF;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Longest legal silence is the history sweep after reset (one entry per cycle);
  // a full-cache miss adds only its search through the chain of cells on top of any stall.
  localparam int WATCHDOG_LIMIT = 20 * HIST_SIZE;
  localparam int DRAIN_CYCLES   = 2 * (2 + NUM_SLOTS) + 8;
  localparam int PHASE_BEATS    = 70;
  localparam int POOL_SIZE      = 24;
  localparam int HAMMER_BEATS   = 12;

  typedef struct packed {
    logic             hit;
    logic             placed;
    logic             replaced_valid;
    logic [KEY_W-1:0] replaced_key;
    logic [CNT_W-1:0] request_count;
    logic [HITS_W-1:0] hit_total;
  } lfu_outcome_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    lfu_outcome_t     outcome;
  } lookup_rec_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    bit               hold;   // wait until every earlier request has answered
  } page_req_t;

  logic clk_i;
  logic rst_ni;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  lfu_req_if                       req_if ();
  lfu_res_if #(.COUNT_BITS(CNT_W)) res_if ();

  lfu_cache_replacement #(
    .SLOTS      (NUM_SLOTS),
    .KEY_SPACE  (HIST_SIZE),
    .COUNT_BITS (CNT_W)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  // Shadow copy of the cache: history counters, cached keys with their own counts,
  // fill level, hit total and the capacity register as last written.
  logic [CNT_W-1:0]  hist_cnt [HIST_SIZE] = '{default: '0};
  logic [KEY_W-1:0]  line_key [NUM_SLOTS];
  logic [CNT_W-1:0]  line_cnt [NUM_SLOTS];
  int unsigned       lines_used = 0;
  logic [HITS_W-1:0] hit_sum    = '0;
  logic [CAP_W-1:0]  cap_shadow = CAP_RESET;

  page_req_t   pending_q [$];
  lookup_rec_t lookup_q  [$];

  int unsigned sent_cnt, done_cnt;
  int          in_flight;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          err_cnt = 0;
  int          idle_cycles = 0;
  int          n_hits = 0, n_fills = 0, n_evicts = 0, n_caps = 0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Work out one request against the shadow cache and advance it.
  function automatic lfu_outcome_t lfu_lookup(logic [KEY_W-1:0] key);
    lfu_outcome_t     o;
    int unsigned      eff_cap;
    int unsigned      victim;
    int unsigned      hidx;
    bit               found;
    logic [CNT_W-1:0] req_cnt;
    o       = '0;
    found   = 1'b0;
    hidx    = key % HIST_SIZE;
    eff_cap = (cap_shadow > NUM_SLOTS) ? NUM_SLOTS : cap_shadow;
    if (hist_cnt[hidx] != CNT_MAX) hist_cnt[hidx] = hist_cnt[hidx] + 1'b1;
    req_cnt = hist_cnt[hidx];
    for (int i = 0; i < lines_used; i++) begin
      if (!found && line_key[i] == key) begin
        found = 1'b1;
        if (line_cnt[i] != CNT_MAX) line_cnt[i] = line_cnt[i] + 1'b1;
      end
    end
    if (found) begin
      o.hit = 1'b1;
      if (hit_sum != '1) hit_sum = hit_sum + 1'b1;
    end else if (eff_cap != 0) begin
      if (lines_used < eff_cap) begin
        line_key[lines_used] = key;
        line_cnt[lines_used] = req_cnt;
        lines_used++;
        o.placed = 1'b1;
      end else if (lines_used > 0) begin
        // later line wins ties, so it is the one that goes
        victim = 0;
        for (int i = 1; i < lines_used; i++)
          if (line_cnt[i] <= line_cnt[victim]) victim = i;
        if (req_cnt > line_cnt[victim]) begin
          o.replaced_valid = 1'b1;
          o.replaced_key   = line_key[victim];
          line_key[victim] = key;
          line_cnt[victim] = req_cnt;
          o.placed         = 1'b1;
        end
      end
    end
    o.request_count = req_cnt;
    o.hit_total     = hit_sum;
    return o;
  endfunction

  // Driver: load the next pending key whenever the request channel is free, idling
  // at random. A held key waits until nothing is outstanding.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.page_key <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      // requests answered after this edge: the counters do not yet count this edge,
      // so add the beat accepted now and drop the result taken now
      in_flight = int'(sent_cnt - done_cnt) + (req_if.valid ? 1 : 0)
                  - ((res_if.valid && res_if.ready) ? 1 : 0);
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(pending_q[0].hold && in_flight != 0)) begin
        req_if.valid    <= 1'b1;
        req_if.page_key <= pending_q[0].key;
        void'(pending_q.pop_front());
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on every accepted request beat, check every result beat
  // against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_rec_t  want;
    lfu_outcome_t got;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      sent_cnt     <= 0;
      done_cnt     <= 0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (req_if.valid && req_if.ready) begin
        lookup_q.push_back('{key: req_if.page_key, outcome: lfu_lookup(req_if.page_key)});
        sent_cnt <= sent_cnt + 1;
      end
      if (res_if.valid && res_if.ready) begin
        done_cnt <= done_cnt + 1;
        got = '{hit: res_if.hit, placed: res_if.placed,
                replaced_valid: res_if.replaced_valid, replaced_key: res_if.replaced_key,
                request_count: res_if.request_count, hit_total: res_if.hit_total};
        n_hits   += (got.hit === 1'b1);
        n_fills  += (got.placed === 1'b1 && got.replaced_valid !== 1'b1);
        n_evicts += (got.replaced_valid === 1'b1);
        if (lookup_q.size() == 0) begin
          if (err_cnt < 10) $display("[%0t] result beat with no request waiting", $realtime);
          err_cnt++;
        end else begin
          want = lookup_q.pop_front();
          if (got !== want.outcome) begin
            if (err_cnt < 10) begin
              $display("[%0t] key %0d: hit %b/%b placed %b/%b evict %b/%b evict_key %0d/%0d",
                       $realtime, want.key, want.outcome.hit, got.hit,
                       want.outcome.placed, got.placed,
                       want.outcome.replaced_valid, got.replaced_valid,
                       want.outcome.replaced_key, got.replaced_key);
              $display("    request_count %0d/%0d hit_total %0d/%0d (expected/actual)",
                       want.outcome.request_count, got.request_count,
                       want.outcome.hit_total, got.hit_total);
            end
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: give up after a long stretch with no beat on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no beat for %0d cycles, %0d results outstanding",
                 $realtime, idle_cycles, lookup_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic queue_key(logic [KEY_W-1:0] key, bit hold = 1'b0);
    pending_q.push_back('{key: key, hold: hold});
  endtask

  // Hold until every queued key has gone out and every result has come back.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (!(pending_q.size() == 0 && !req_if.valid && sent_cnt == done_cnt));
  endtask

  // Capacity writes only land on an idle block; mirror them in the shadow cache.
  task automatic set_capacity(logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    cap_shadow  = cap;
    n_caps++;
  endtask

  // Mostly keys from a small pool so history builds up and evictions happen; a
  // quarter spread over the whole key range. Now and then hold a key back.
  task automatic queue_random_phase(int beats);
    for (int i = 0; i < beats; i++) begin
      if ($urandom_range(3) != 0)
        queue_key(key_pool[$urandom_range(POOL_SIZE - 1)], $urandom_range(39) == 0);
      else
        queue_key(KEY_W'($urandom_range((1 << KEY_W) - 1)), $urandom_range(39) == 0);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps [6];
    phase_caps = '{CAP_W'(8), CAP_W'(16), CAP_W'(0), CAP_W'(1), CAP_W'(20), CAP_W'(31)};
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom_range((1 << KEY_W) - 1));

    rst_ni     = 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Capacity zero with nothing cached: history counts, never places.
    set_capacity(CAP_W'(0));
    queue_key(KEY_W'(0));
    queue_key(KEY_W'(1023));
    queue_key(KEY_W'(10'h2AA));
    queue_key(KEY_W'(10'h155));

    // Two lines: fill both, hit, then a miss that loses, one that ties and loses,
    // one that wins, and a miss against a tie on the line counts that does not evict.
    set_capacity(CAP_W'(2));
    queue_key(KEY_W'(10'h155));
    queue_key(KEY_W'(10'h2AA));
    queue_key(KEY_W'(10'h155));
    queue_key(KEY_W'(10'h300));
    queue_key(KEY_W'(10'h300));
    queue_key(KEY_W'(10'h300));
    queue_key(KEY_W'(10'h2AA));
    queue_key(KEY_W'(1023));
    queue_key(KEY_W'(10'h155), 1'b1);

    // Register above the line count behaves as a full-size cache.
    set_capacity(CAP_W'(31));
    queue_key(KEY_W'(1023));
    queue_key(KEY_W'(0));
    queue_key(KEY_W'(1023));
    queue_key(KEY_W'(0));
    queue_key(KEY_W'(10'h2AA));

    // Random phases: sender idles lightly and receiver heavily, then the reverse,
    // then neither. Capacity walks through mid values, zero, below occupancy and
    // above the line count.
    for (int p = 0; p < 6; p++) begin
      set_capacity(phase_caps[p]);
      send_idle_pct = (p < 2) ? 9 : (p < 4) ? 52 : 0;
      recv_idle_pct = (p < 2) ? 52 : (p < 4) ? 9 : 0;
      queue_random_phase(PHASE_BEATS);
    end

    // Hammer one key so its history and line counts climb well past the rest.
    set_capacity(CAP_W'(16));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < HAMMER_BEATS; i++) queue_key(key_pool[2]);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (lookup_q.size() != 0) begin
      $display("%0d results never arrived", lookup_q.size());
      err_cnt++;
    end

    $display("Covered %0d requests over %0d capacity writes, ending on a burst of one key",
             sent_cnt, n_caps);
    $display("Saw %0d hits, %0d fills into free lines, %0d evictions; %0d mismatches",
             n_hits, n_fills, n_evicts, err_cnt);
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lfu_pkg.sv
rtl/core/lfu_req_if.sv
rtl/core/lfu_res_if.sv
rtl/core/lfu_hist_mem.sv
rtl/core/lfu_cell.sv
rtl/core/lfu_cache_replacement.sv
tb/sv/tb.sv
